// ===== rtl/core/dwo_pkg.sv =====
// Shared constants, types and the arctangent table of the dead-wheel odometry block.
// Used by the sequencer, the CORDIC unit and the testbench.
`timescale 1ns / 1ps
package dwo_pkg;

  localparam int ANGLE_BITS   = 16;
  localparam int ATAN_LEN     = 24;
  localparam int CORDIC_ITERS = (ANGLE_BITS < ATAN_LEN) ? ANGLE_BITS : ATAN_LEN;
  localparam int CNT_W        = $clog2(CORDIC_ITERS);

  localparam logic signed [32:0] TWO_PI_Q28   = 33'sd1686629713;
  localparam logic signed [33:0] CORDIC_K_Q30 = 34'sd652032874;

  localparam logic [1:0] CFG_X_SCALE = 2'd0;
  localparam logic [1:0] CFG_Y_SCALE = 2'd1;
  localparam logic [1:0] CFG_X_LEVER = 2'd2;
  localparam logic [1:0] CFG_Y_LEVER = 2'd3;

  typedef struct packed {
    logic              done;
    logic signed [33:0] cos_v;
    logic signed [33:0] sin_v;
  } cordic_res_t;

  function automatic logic [31:0] atan_of(input logic [4:0] idx);
    logic [31:0] r;
    unique case (idx)
      5'd0:  r = 32'd536870912;
      5'd1:  r = 32'd316933406;
      5'd2:  r = 32'd167458907;
      5'd3:  r = 32'd85004756;
      5'd4:  r = 32'd42667331;
      5'd5:  r = 32'd21354465;
      5'd6:  r = 32'd10679838;
      5'd7:  r = 32'd5340245;
      5'd8:  r = 32'd2670163;
      5'd9:  r = 32'd1335087;
      5'd10: r = 32'd667544;
      5'd11: r = 32'd333772;
      5'd12: r = 32'd166886;
      5'd13: r = 32'd83443;
      5'd14: r = 32'd41722;
      5'd15: r = 32'd20861;
      5'd16: r = 32'd10430;
      5'd17: r = 32'd5215;
      5'd18: r = 32'd2608;
      5'd19: r = 32'd1304;
      5'd20: r = 32'd652;
      5'd21: r = 32'd326;
      5'd22: r = 32'd163;
      5'd23: r = 32'd81;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/core/dwo_mul.sv =====
// Shared signed 33 x 33 multiplier with a registered product.
// Depends on nothing beyond the clock.
`timescale 1ns / 1ps
module dwo_mul (
  input  logic               clk,
  input  logic signed [32:0] a,
  input  logic signed [32:0] b,
  output logic signed [65:0] p_r
);
  logic signed [65:0] p_nxt;

  assign p_nxt = 66'(a) * 66'(b);

  always_ff @(posedge clk) begin
    p_r <= p_nxt;
  end
endmodule

// ===== rtl/core/dwo_cordic.sv =====
// Iterative CORDIC sine and cosine, one rotation per cycle.
// Depends on dwo_pkg for the iteration count, gain and arctangent table.
`timescale 1ns / 1ps
module dwo_cordic (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [31:0]        turn,
  output dwo_pkg::cordic_res_t res
);
  localparam logic [dwo_pkg::CNT_W-1:0] LAST = dwo_pkg::CNT_W'(dwo_pkg::CORDIC_ITERS - 1);
  localparam logic signed [32:0] QUARTER = 33'sd1073741824;
  localparam logic signed [32:0] HALF    = 33'sd2147483648;

  logic signed [33:0] x_r, y_r, xs, ys;
  logic signed [32:0] z_r, zs, z0, at;
  logic [dwo_pkg::CNT_W-1:0] i_r;
  logic busy_r, done_r, flip_r, flip0;

  assign zs = signed'({turn[31], turn});

  always_comb begin
    z0    = zs;
    flip0 = 1'b0;
    if (zs > QUARTER) begin
      z0    = zs - HALF;
      flip0 = 1'b1;
    end else if (zs < -QUARTER) begin
      z0    = zs + HALF;
      flip0 = 1'b1;
    end
  end

  assign xs = x_r >>> i_r;
  assign ys = y_r >>> i_r;
  assign at = signed'({1'b0, dwo_pkg::atan_of(5'(i_r))});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      x_r    <= dwo_pkg::CORDIC_K_Q30;
      y_r    <= '0;
      z_r    <= z0;
      flip_r <= flip0;
      i_r    <= '0;
    end else if (busy_r) begin
      if (z_r >= 0) begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - at;
      end else begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + at;
      end
      if (i_r == LAST) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end else begin
        i_r <= i_r + 1'b1;
      end
    end
  end

  assign res.done  = done_r;
  assign res.cos_v = flip_r ? -x_r : x_r;
  assign res.sin_v = flip_r ? -y_r : y_r;
endmodule

// ===== rtl/core/deadwheel_odometry_pose.sv =====
// Top level of the dead-wheel odometry block: sequencer, pose state and stream ports.
// Depends on dwo_pkg, dwo_mul and dwo_cordic.
`timescale 1ns / 1ps
// An odometry update passes nine products in turn through the one shared multiplier, while
// the 16-step CORDIC for the midpoint heading runs alongside them. A set-pose item and the
// first update skip the arithmetic and go straight to the output state. One item is worked
// at a time; the next is accepted once the sequencer is idle, while the previous result may
// still wait in the output register.
module deadwheel_odometry_pose (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // enc_x, enc_y, imu_angle, time_tick, new_x, new_y, new_heading
  input  logic [191:0] in_tdata,
  // func
  input  logic         in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // pos_x, pos_y, heading_out, tick_out, pose_valid, zero fill
  output logic [119:0] out_tdata,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_addr,
  input  logic [31:0]  cfg_wdata
);
  typedef enum logic [3:0] {
    S_IDLE, S_MX, S_MY, S_RD, S_RA, S_LX, S_LY, S_LD, S_WT,
    S_F0, S_F1, S_F2, S_F3, S_F4, S_F5, S_OUT
  } state_t;

  state_t state_r;

  logic signed [31:0] xs_r, ys_r, xl_r, yl_r;
  logic started_r, valid_r;
  logic signed [31:0] lcx_r, lcy_r, acc_x_r, acc_y_r;
  logic [15:0] zero_r, last_r, pang_r, dh_r;
  logic [31:0] ptick_r, turn_r;
  logic signed [32:0] dx_r, dy_r, rad_r, c_r, s_r, mul_a, mul_b;
  logic signed [49:0] mx_r, my_r;
  logic signed [31:0] dxr_r, dyr_r;
  logic signed [65:0] p_r, t_r, sum_r;
  logic signed [31:0] o_x_r, o_y_r;
  logic [15:0] o_h_r;
  logic [31:0] o_t_r;
  logic o_v_r, o_valid_r, cstart;
  dwo_pkg::cordic_res_t cres;

  logic signed [31:0] ex, ey;
  logic [15:0] imu, heading, draw;
  logic [16:0] mid17;

  function automatic logic signed [65:0] rnd(input logic signed [65:0] v, input int s);
    return (v + (66'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7fffffff;
    if (v < -66'sd2147483648) return 32'sh80000000;
    return 32'(v);
  endfunction

  assign ex      = signed'(in_tdata[31:0]);
  assign ey      = signed'(in_tdata[63:32]);
  assign imu     = in_tdata[79:64];
  assign heading = imu - zero_r;
  assign draw    = heading - last_r;
  assign mid17   = {last_r, 1'b0} + {draw[15], draw};

  assign in_tready = (state_r == S_IDLE);
  assign cstart    = (state_r == S_MX);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xs_r <= '0;
      ys_r <= '0;
      xl_r <= '0;
      yl_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        dwo_pkg::CFG_X_SCALE: xs_r <= signed'(cfg_wdata);
        dwo_pkg::CFG_Y_SCALE: ys_r <= signed'(cfg_wdata);
        dwo_pkg::CFG_X_LEVER: xl_r <= signed'(cfg_wdata);
        dwo_pkg::CFG_Y_LEVER: yl_r <= signed'(cfg_wdata);
      endcase
    end
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_MX: begin mul_a = dx_r; mul_b = 33'(xs_r); end
      S_MY: begin mul_a = dy_r; mul_b = 33'(ys_r); end
      S_RD: begin mul_a = 33'(signed'(dh_r)); mul_b = dwo_pkg::TWO_PI_Q28; end
      S_LX: begin mul_a = 33'(xl_r); mul_b = rad_r; end
      S_LY: begin mul_a = 33'(yl_r); mul_b = rad_r; end
      S_F0: begin mul_a = c_r; mul_b = 33'(dxr_r); end
      S_F1: begin mul_a = s_r; mul_b = 33'(dyr_r); end
      S_F2: begin mul_a = s_r; mul_b = 33'(dxr_r); end
      S_F3: begin mul_a = c_r; mul_b = 33'(dyr_r); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  dwo_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p_r(p_r));

  dwo_cordic u_cordic (
    .clk(clk), .rst_n(rst_n), .start(cstart), .turn(turn_r), .res(cres)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      started_r <= 1'b0;
      valid_r   <= 1'b0;
      lcx_r     <= '0;
      lcy_r     <= '0;
      zero_r    <= '0;
      last_r    <= '0;
      acc_x_r   <= '0;
      acc_y_r   <= '0;
      pang_r    <= '0;
      ptick_r   <= '0;
      o_valid_r <= 1'b0;
    end else begin
      if (o_valid_r && out_tready && state_r != S_OUT) o_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: if (in_tvalid) begin
          if (in_tuser) begin
            acc_x_r <= signed'(in_tdata[143:112]);
            acc_y_r <= signed'(in_tdata[175:144]);
            pang_r  <= in_tdata[191:176];
            state_r <= S_OUT;
          end else if (!started_r) begin
            lcx_r     <= ex;
            lcy_r     <= ey;
            zero_r    <= imu;
            last_r    <= '0;
            pang_r    <= '0;
            acc_x_r   <= '0;
            acc_y_r   <= '0;
            ptick_r   <= in_tdata[111:80];
            valid_r   <= 1'b1;
            started_r <= 1'b1;
            state_r   <= S_OUT;
          end else begin
            dx_r    <= 33'(ex) - 33'(lcx_r);
            dy_r    <= 33'(ey) - 33'(lcy_r);
            dh_r    <= draw;
            turn_r  <= {mid17, 15'd0};
            lcx_r   <= ex;
            lcy_r   <= ey;
            pang_r  <= heading;
            last_r  <= heading;
            ptick_r <= in_tdata[111:80];
            valid_r <= 1'b1;
            state_r <= S_MX;
          end
        end
        S_MX: state_r <= S_MY;
        S_MY: begin
          mx_r    <= 50'(rnd(p_r, 16));
          state_r <= S_RD;
        end
        S_RD: begin
          my_r    <= 50'(rnd(p_r, 16));
          state_r <= S_RA;
        end
        S_RA: begin
          rad_r   <= 33'(rnd(p_r, 16));
          state_r <= S_LX;
        end
        S_LX: state_r <= S_LY;
        S_LY: begin
          dxr_r   <= sat32(66'(mx_r) + rnd(p_r, 28));
          state_r <= S_LD;
        end
        S_LD: begin
          dyr_r   <= sat32(66'(my_r) - rnd(p_r, 28));
          state_r <= S_WT;
        end
        S_WT: if (cres.done) begin
          c_r     <= 33'(cres.cos_v);
          s_r     <= 33'(cres.sin_v);
          state_r <= S_F0;
        end
        S_F0: state_r <= S_F1;
        S_F1: begin
          t_r     <= p_r;
          state_r <= S_F2;
        end
        S_F2: begin
          sum_r   <= t_r - p_r;
          state_r <= S_F3;
        end
        S_F3: begin
          acc_x_r <= sat32(66'(acc_x_r) + rnd(sum_r, 30));
          t_r     <= p_r;
          state_r <= S_F4;
        end
        S_F4: begin
          sum_r   <= t_r + p_r;
          state_r <= S_F5;
        end
        S_F5: begin
          acc_y_r <= sat32(66'(acc_y_r) + rnd(sum_r, 30));
          state_r <= S_OUT;
        end
        S_OUT: if (!o_valid_r || out_tready) begin
          o_x_r     <= acc_x_r;
          o_y_r     <= acc_y_r;
          o_h_r     <= pang_r;
          o_t_r     <= ptick_r;
          o_v_r     <= valid_r;
          o_valid_r <= 1'b1;
          state_r   <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = o_valid_r;
  assign out_tdata  = {7'd0, o_v_r, o_t_r, o_h_r, o_y_r, o_x_r};
endmodule

// ===== rtl/core/dwo_checker.sv =====
// Port-level checker for the dead-wheel odometry block, bound to the top level.
// Depends only on the top level's port names.
`timescale 1ns / 1ps
module dwo_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [119:0] out_tdata
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result item changed while stalled");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while an item was in work");

  a_valid_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    $past(out_tvalid && out_tdata[112]) && out_tvalid |-> out_tdata[112])
    else $error("pose valid flag fell");

  a_out_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !$isunknown(out_tdata))
    else $error("result item holds unknown bits");
endmodule

bind deadwheel_odometry_pose dwo_checker u_dwo_checker (.*);

// ===== test/deadwheel_odometry_pose_tb.sv =====
// Self-checking testbench for the dead-wheel odometry block: directed and random pose items.
// A scoreboard class predicts each pose; depends on dwo_pkg and deadwheel_odometry_pose.
`timescale 1ns / 1ps
module deadwheel_odometry_pose_tb;

  localparam longint CYCLE_LIMIT = 2000000;

  typedef struct {
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [15:0] heading_out;
    logic [31:0] tick_out;
    logic        pose_valid;
  } pose_t;

  class pose_scoreboard;
    longint x_scale, y_scale, x_lever, y_lever;
    bit started, valid_flag;
    longint last_cx, last_cy, acc_x, acc_y;
    bit [15:0] angle_zero, last_angle, pose_angle;
    bit [31:0] pose_tick;
    pose_t pending[$];
    int errors;

    function longint shr_round(longint v, int s);
      return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function longint atan_turn(int i);
      longint t[24] = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
                        41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81};
      return t[i];
    endfunction

    function void sin_cos(bit [31:0] turn, output longint c, output longint s);
      longint z, x, y, xs, ys;
      bit flip;
      z = longint'(signed'(turn));
      x = 652032874;
      y = 0;
      flip = 0;
      if (z > 64'sd1073741824) begin
        z -= 64'sd2147483648; flip = 1;
      end else if (z < -64'sd1073741824) begin
        z += 64'sd2147483648; flip = 1;
      end
      for (int i = 0; i < dwo_pkg::CORDIC_ITERS; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (z >= 0) begin
          x -= ys; y += xs; z -= atan_turn(i);
        end else begin
          x += ys; y -= xs; z += atan_turn(i);
        end
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] v);
      longint sv;
      sv = longint'(signed'(v));
      case (idx)
        dwo_pkg::CFG_X_SCALE: x_scale = sv;
        dwo_pkg::CFG_Y_SCALE: y_scale = sv;
        dwo_pkg::CFG_X_LEVER: x_lever = sv;
        dwo_pkg::CFG_Y_LEVER: y_lever = sv;
      endcase
    endfunction

    function void note_item(logic func, logic [191:0] d);
      longint ex, ey, dh, mx, my, rad, dxr, dyr, c, s;
      bit [15:0] imu, heading, draw;
      bit [16:0] mid;
      pose_t p;
      ex = longint'(signed'(d[31:0]));
      ey = longint'(signed'(d[63:32]));
      imu = d[79:64];
      if (func) begin
        acc_x = longint'(signed'(d[143:112]));
        acc_y = longint'(signed'(d[175:144]));
        pose_angle = d[191:176];
      end else if (!started) begin
        last_cx = ex; last_cy = ey;
        angle_zero = imu; last_angle = 0; pose_angle = 0;
        acc_x = 0; acc_y = 0;
        pose_tick = d[111:80];
        valid_flag = 1; started = 1;
      end else begin
        heading = imu - angle_zero;
        draw = heading - last_angle;
        dh = longint'(signed'(draw));
        mx = shr_round((ex - last_cx) * x_scale, 16);
        my = shr_round((ey - last_cy) * y_scale, 16);
        rad = shr_round(dh * 64'sd1686629713, 16);
        dxr = clamp32(mx + shr_round(x_lever * rad, 28));
        dyr = clamp32(my - shr_round(y_lever * rad, 28));
        mid = {last_angle, 1'b0} + 17'(dh);
        sin_cos({mid, 15'd0}, c, s);
        acc_x = clamp32(acc_x + shr_round(c * dxr - s * dyr, 30));
        acc_y = clamp32(acc_y + shr_round(s * dxr + c * dyr, 30));
        last_cx = ex; last_cy = ey;
        pose_angle = heading; last_angle = heading;
        pose_tick = d[111:80];
        valid_flag = 1;
      end
      p.pos_x = acc_x[31:0];
      p.pos_y = acc_y[31:0];
      p.heading_out = pose_angle;
      p.tick_out = pose_tick;
      p.pose_valid = valid_flag;
      pending.push_back(p);
    endfunction

    function void check_pose(logic [119:0] d);
      pose_t e;
      if (pending.size() == 0) begin
        $error("pose result with nothing expected: %h", d);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (d[31:0] !== e.pos_x) begin
        $error("pos_x expected %h actual %h", e.pos_x, d[31:0]); errors++;
      end
      if (d[63:32] !== e.pos_y) begin
        $error("pos_y expected %h actual %h", e.pos_y, d[63:32]); errors++;
      end
      if (d[79:64] !== e.heading_out) begin
        $error("heading_out expected %h actual %h", e.heading_out, d[79:64]); errors++;
      end
      if (d[111:80] !== e.tick_out) begin
        $error("tick_out expected %h actual %h", e.tick_out, d[111:80]); errors++;
      end
      if (d[112] !== e.pose_valid) begin
        $error("pose_valid expected %b actual %b", e.pose_valid, d[112]); errors++;
      end
    endfunction
  endclass

  logic clk = 0, rst_n = 0;
  logic in_tvalid = 0, in_tuser = 0, out_tready = 0;
  logic [191:0] in_tdata = '0;
  logic in_tready, out_tvalid;
  logic [119:0] out_tdata;
  logic cfg_we = 0;
  logic [1:0] cfg_addr = '0;
  logic [31:0] cfg_wdata = '0;
  pose_scoreboard sb;
  longint cycles = 0;
  int rx_hold = 0;
  bit stim_done = 0;
  logic [31:0] enc_x_now, enc_y_now;
  logic [15:0] imu_now;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  deadwheel_odometry_pose u_top (.*);

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
    if (out_tvalid && out_tready) sb.check_pose(out_tdata);
  end

  initial begin : receiver
    int w;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (rx_hold > 0) begin
        out_tready <= 0;
        repeat (rx_hold) @(negedge clk);
        rx_hold = 0;
      end
      w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
      if (w > 0) begin
        out_tready <= 0;
        repeat (w) @(negedge clk);
      end
      out_tready <= 1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  task automatic write_cfg(logic [1:0] idx, logic [31:0] v);
    @(negedge clk);
    cfg_we <= 1; cfg_addr <= idx; cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 0;
    sb.write_reg(idx, v);
  endtask

  task automatic send_item(logic func, logic [191:0] d, bit gap_ok);
    int w;
    w = gap_ok ? (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14)) : 0;
    if (w > 0) begin
      @(negedge clk);
      in_tvalid <= 0;
      repeat (w - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1; in_tuser <= func; in_tdata <= d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_item(func, d);
  endtask

  function automatic logic [191:0] odo(logic [31:0] ex, logic [31:0] ey, logic [15:0] a);
    return {16'($urandom), 32'($urandom), 32'($urandom), 32'($urandom), a, ey, ex};
  endfunction

  function automatic logic [191:0] setp(logic [31:0] x, logic [31:0] y, logic [15:0] h);
    return {h, y, x, 32'($urandom), 16'($urandom), 32'($urandom), 32'($urandom)};
  endfunction

  task automatic drain();
    @(negedge clk);
    in_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  function automatic logic [31:0] rnd_scale();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'd0;
      default: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
    endcase
  endfunction

  task automatic random_phase(int n, bit rough);
    logic [31:0] dx, dy;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 19) == 0) begin
        send_item(1, setp($urandom, $urandom, 16'($urandom)), 1);
      end else begin
        if (rough || $urandom_range(0, 29) == 0) begin
          dx = $urandom; dy = $urandom;
          imu_now = 16'($urandom);
        end else begin
          dx = 32'($signed($urandom_range(0, 4000)) - 2000);
          dy = 32'($signed($urandom_range(0, 4000)) - 2000);
          imu_now += 16'($signed($urandom_range(0, 4000)) - 2000);
        end
        enc_x_now += dx; enc_y_now += dy;
        send_item(0, odo(enc_x_now, enc_y_now, imu_now), 1);
      end
    end
  endtask

  initial begin
    sb = new();
    enc_x_now = 0; enc_y_now = 0; imu_now = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1;
    write_cfg(dwo_pkg::CFG_X_SCALE, 32'd42950);
    write_cfg(dwo_pkg::CFG_Y_SCALE, -32'sd42950);
    write_cfg(dwo_pkg::CFG_X_LEVER, 32'h0000_8000);
    write_cfg(dwo_pkg::CFG_Y_LEVER, 32'hffff_4000);
    // Set pose before any update, then the first update at extreme counts.
    send_item(1, setp(32'h7fffffff, 32'h80000000, 16'hffff), 0);
    send_item(0, odo(32'h80000000, 32'h7fffffff, 16'h1234), 0);
    send_item(0, odo(32'h80000100, 32'h7ffffe00, 16'h1234 + 16'h8000), 0);
    send_item(0, odo(32'h80000100, 32'h7ffffe00, 16'h1234), 0);
    send_item(0, odo(32'h7fffffff, 32'h80000000, 16'h1234 + 16'h7fff), 0);
    send_item(1, setp(32'h0001_0000, 32'hffff_0000, 16'h4000), 0);
    send_item(0, odo(32'h7fffffff, 32'h80000000, 16'h1234), 0);
    send_item(0, odo(32'hffffffff, 32'h00000000, 16'h0000), 0);
    send_item(0, odo(32'h00000000, 32'hffffffff, 16'hffff), 0);
    send_item(0, odo(32'hffffffff, 32'hffffffff, 16'h1234 + 16'hc000), 0);
    drain();
    // Extreme registers make huge jumps saturate.
    write_cfg(dwo_pkg::CFG_X_SCALE, 32'h7fffffff);
    write_cfg(dwo_pkg::CFG_Y_SCALE, 32'h80000000);
    write_cfg(dwo_pkg::CFG_X_LEVER, 32'h80000000);
    write_cfg(dwo_pkg::CFG_Y_LEVER, 32'h7fffffff);
    send_item(0, odo(32'h7fffffff, 32'h80000000, 16'h9234), 0);
    send_item(0, odo(32'h80000000, 32'h7fffffff, 16'h1234), 0);
    send_item(0, odo(32'h7fffffff, 32'h80000000, 16'h5234), 0);
    send_item(0, odo(32'h80000000, 32'h7fffffff, 16'hd234), 0);
    send_item(1, setp(32'h80000000, 32'h7fffffff, 16'h0000), 0);
    send_item(0, odo(32'h00000000, 32'h00000000, 16'h0000), 0);
    drain();
    for (int ph = 0; ph < 6; ph++) begin
      write_cfg(dwo_pkg::CFG_X_SCALE, rnd_scale());
      write_cfg(dwo_pkg::CFG_Y_SCALE, rnd_scale());
      write_cfg(dwo_pkg::CFG_X_LEVER, rnd_scale());
      write_cfg(dwo_pkg::CFG_Y_LEVER, rnd_scale());
      if (ph == 2) begin
        rx_hold = 300;
        random_phase(40, 0);
      end
      random_phase(260, ph == 5);
      drain();
    end
    write_cfg(dwo_pkg::CFG_X_SCALE, 32'd0);
    write_cfg(dwo_pkg::CFG_Y_SCALE, 32'd0);
    write_cfg(dwo_pkg::CFG_X_LEVER, 32'd0);
    write_cfg(dwo_pkg::CFG_Y_LEVER, 32'd0);
    random_phase(40, 1);
    drain();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
